FILE: rtl/cpp_pkg.sv
// Shared types and constants for the camera point projection block.
// Used by cpp_front, cpp_fifo, cpp_back and camera_point_projection; no dependencies.
`timescale 1ns / 1ps

package cpp_pkg;

  localparam int unsigned NumRegs   = 6;
  localparam int unsigned RegW      = 64;
  localparam int unsigned AddrW     = 6;
  localparam int unsigned CoefW     = 32;
  localparam int unsigned ProdW     = 64;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned TermW     = ProdW - FracBits;   // 48
  localparam int unsigned SumW      = 50;
  localparam int unsigned MagW      = 48;
  localparam int unsigned DivSteps  = 32;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = 2;
  localparam int unsigned FifoCntW  = 3;

  localparam logic [31:0] QNegOne = 32'hFFFF_0000;
  localparam logic [31:0] SatPos  = 32'h7FFF_FFFF;
  localparam logic [31:0] SatNeg  = 32'h8000_0000;

  typedef enum logic [2:0] {
    RegRow0A = 3'd0,
    RegRow0B = 3'd1,
    RegRow1A = 3'd2,
    RegRow1B = 3'd3,
    RegRow2A = 3'd4,
    RegRow2B = 3'd5
  } reg_idx_e;

  localparam logic [RegW-1:0] ResetRow0A = 64'h0001_0000_0000_0000;
  localparam logic [RegW-1:0] ResetRow0B = 64'h0;
  localparam logic [RegW-1:0] ResetRow1A = 64'h0000_0000_0001_0000;
  localparam logic [RegW-1:0] ResetRow1B = 64'h0;
  localparam logic [RegW-1:0] ResetRow2A = 64'h0;
  localparam logic [RegW-1:0] ResetRow2B = 64'h0001_0000_0000_0000;

  // 3x4 projection matrix, [row][col]
  typedef logic [2:0][3:0][CoefW-1:0] coef_mat_t;

  // Classified request handed from front to back
  typedef struct packed {
    logic            in_front;
    logic            neg_u;
    logic            neg_v;
    logic [MagW-1:0] mag_u;
    logic [MagW-1:0] mag_v;
    logic [MagW-1:0] den;
  } job_t;

  // One divider lane between steps
  typedef struct packed {
    logic                neg;
    logic                ovf;
    logic [MagW-1:0]     rem;
    logic [DivSteps-1:0] feed;
    logic [DivSteps-1:0] quo;
  } lane_t;

  typedef struct packed {
    logic            in_front;
    logic [MagW-1:0] den;
    lane_t           u;
    lane_t           v;
  } div_stage_t;

endpackage

FILE: rtl/cpp_front.sv
// Front part: accepts points, forms the homogeneous image vector and classifies it.
// Depends on cpp_pkg.
`timescale 1ns / 1ps

module cpp_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cpp_pkg::coef_mat_t coef_i,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] point_z_i,
  input  logic               job_full_i,
  output logic               job_valid_o,
  output cpp_pkg::job_t      job_o
);

  logic en;
  logic v1_q, v2_q, v3_q, v4_q;

  logic signed [cpp_pkg::ProdW-1:0] prod_d [3][3];
  logic signed [cpp_pkg::ProdW-1:0] prod_q [3][3];
  logic signed [cpp_pkg::CoefW-1:0] off_q  [3];
  logic signed [cpp_pkg::SumW-1:0]  pa_d [3], pb_d [3];
  logic signed [cpp_pkg::SumW-1:0]  pa_q [3], pb_q [3];
  logic signed [cpp_pkg::SumW-1:0]  sum_d [3];
  logic signed [cpp_pkg::SumW-1:0]  sum_q [3];
  logic signed [cpp_pkg::SumW-1:0]  neg_x, neg_y;
  cpp_pkg::job_t job_d, job_q;
  logic signed [31:0] pt [3];

  // Hold the whole front while the queue refuses the oldest request
  assign en   = !(v4_q && job_full_i);
  assign full = !en;

  assign pt[0] = point_x_i;
  assign pt[1] = point_y_i;
  assign pt[2] = point_z_i;

  // Products of coefficients and coordinates
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_d[r][c] = $signed(coef_i[r][c]) * pt[c];
      end
    end
  end

  // Floor to Q16.16 and pair up the terms
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      pa_d[r] = $signed({{2{prod_q[r][0][cpp_pkg::ProdW-1]}},
                         prod_q[r][0][cpp_pkg::ProdW-1:cpp_pkg::FracBits]})
              + $signed({{2{prod_q[r][1][cpp_pkg::ProdW-1]}},
                         prod_q[r][1][cpp_pkg::ProdW-1:cpp_pkg::FracBits]});
      pb_d[r] = $signed({{2{prod_q[r][2][cpp_pkg::ProdW-1]}},
                         prod_q[r][2][cpp_pkg::ProdW-1:cpp_pkg::FracBits]})
              + $signed({{(cpp_pkg::SumW-cpp_pkg::CoefW){off_q[r][cpp_pkg::CoefW-1]}},
                         off_q[r]});
      sum_d[r] = pa_q[r] + pb_q[r];
    end
  end

  // Classify depth and take magnitudes
  always_comb begin
    neg_x = -sum_q[0];
    neg_y = -sum_q[1];
    job_d.in_front = !sum_q[2][cpp_pkg::SumW-1] && (sum_q[2] != '0);
    job_d.neg_u    = sum_q[0][cpp_pkg::SumW-1];
    job_d.neg_v    = sum_q[1][cpp_pkg::SumW-1];
    job_d.mag_u    = job_d.neg_u ? neg_x[cpp_pkg::MagW-1:0] : sum_q[0][cpp_pkg::MagW-1:0];
    job_d.mag_v    = job_d.neg_v ? neg_y[cpp_pkg::MagW-1:0] : sum_q[1][cpp_pkg::MagW-1:0];
    job_d.den      = sum_q[2][cpp_pkg::MagW-1:0];
  end

  // Advance stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= push;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // Advance stage payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[r][c] <= prod_d[r][c];
        end
        off_q[r] <= $signed(coef_i[r][3]);
        pa_q[r]  <= pa_d[r];
        pb_q[r]  <= pb_d[r];
        sum_q[r] <= sum_d[r];
      end
      job_q <= job_d;
    end
  end

  assign job_valid_o = v4_q;
  assign job_o       = job_q;

`ifndef SYNTHESIS
  a_full_only_when_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> (v4_q && job_full_i))
    else $error("front reports full without a held request");
`endif

endmodule

FILE: rtl/cpp_fifo.sv
// Short request queue between the front and back parts.
// Depends on cpp_pkg (job_t, depth constants).
`timescale 1ns / 1ps

module cpp_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  input  cpp_pkg::job_t wr_data_i,
  output logic          full_o,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output cpp_pkg::job_t rd_data_o
);

  cpp_pkg::job_t                 mem_q [cpp_pkg::FifoDepth];
  logic [cpp_pkg::FifoPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [cpp_pkg::FifoCntW-1:0]  cnt_q, cnt_d;
  logic                          wr_en, rd_en;

  assign full_o     = (cnt_q == cpp_pkg::FifoCntW'(cpp_pkg::FifoDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign wr_en      = wr_valid_i && !full_o;
  assign rd_en      = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (wr_en && !rd_en) cnt_d = cnt_q + 1'b1;
    if (rd_en && !wr_en) cnt_d = cnt_q - 1'b1;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (rd_en) rd_ptr_q <= rd_ptr_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

  // Store the request
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_ptr_q] <= wr_data_i;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= cpp_pkg::FifoCntW'(cpp_pkg::FifoDepth))
    else $error("queue fill count beyond depth");
  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && !rd_en) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue fill count missed a write");
`endif

endmodule

FILE: rtl/cpp_back.sv
// Back part: pipelined restoring divider for u and v, saturation and result register.
// Depends on cpp_pkg (job_t, lane_t, div_stage_t, constants).
`timescale 1ns / 1ps

module cpp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  input  cpp_pkg::job_t      job_i,
  output logic               job_ready_o,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] pixel_u_o,
  output logic signed [31:0] pixel_v_o,
  output logic               in_front_o
);

  // One restoring step: bring in the next numerator bit, subtract if it fits
  function automatic cpp_pkg::lane_t div_step(cpp_pkg::lane_t l, logic [cpp_pkg::MagW-1:0] den);
    cpp_pkg::lane_t          n;
    logic [cpp_pkg::MagW:0]  t;
    logic [cpp_pkg::MagW:0]  d;
    n = l;
    t = {l.rem, l.feed[cpp_pkg::DivSteps-1]};
    d = {1'b0, den};
    n.feed = {l.feed[cpp_pkg::DivSteps-2:0], 1'b0};
    if (t >= d) begin
      t     = t - d;
      n.quo = {l.quo[cpp_pkg::DivSteps-2:0], 1'b1};
    end else begin
      n.quo = {l.quo[cpp_pkg::DivSteps-2:0], 1'b0};
    end
    n.rem = t[cpp_pkg::MagW-1:0];
    return n;
  endfunction

  // Start a lane: overflow check and upper numerator bits as first remainder
  function automatic cpp_pkg::lane_t lane_init(logic neg, logic [cpp_pkg::MagW-1:0] mag,
                                               logic [cpp_pkg::MagW-1:0] den);
    cpp_pkg::lane_t l;
    l.neg  = neg;
    l.ovf  = ({16'h0, mag} >= {den, 16'h0});
    l.rem  = {16'h0, mag[cpp_pkg::MagW-1:cpp_pkg::FracBits]};
    l.feed = {mag[cpp_pkg::FracBits-1:0], 16'h0};
    l.quo  = '0;
    return l;
  endfunction

  // Apply sign and saturation
  function automatic logic [31:0] lane_final(cpp_pkg::lane_t l);
    logic [31:0] r;
    if (l.neg) begin
      r = (l.ovf || (l.quo > cpp_pkg::SatNeg)) ? cpp_pkg::SatNeg : (32'h0 - l.quo);
    end else begin
      r = (l.ovf || (l.quo > cpp_pkg::SatPos)) ? cpp_pkg::SatPos : l.quo;
    end
    return r;
  endfunction

  cpp_pkg::div_stage_t st_q [cpp_pkg::DivSteps+1];
  logic [cpp_pkg::DivSteps:0] sv_q;
  logic        out_valid_q;
  logic [31:0] u_q, v_q;
  logic        flag_q;
  logic        en;
  cpp_pkg::div_stage_t st0_d;

  // Hold the pipeline only while a result waits and is not taken
  assign en          = !(out_valid_q && !pop);
  assign job_ready_o = en;

  always_comb begin
    st0_d.in_front = job_i.in_front;
    st0_d.den      = job_i.den;
    st0_d.u        = lane_init(job_i.neg_u, job_i.mag_u, job_i.den);
    st0_d.v        = lane_init(job_i.neg_v, job_i.mag_v, job_i.den);
  end

  // Advance valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q        <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      sv_q        <= {sv_q[cpp_pkg::DivSteps-1:0], job_valid_i};
      out_valid_q <= sv_q[cpp_pkg::DivSteps];
    end
  end

  // Advance divider stages and the result register
  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q[0] <= st0_d;
      for (int i = 1; i <= cpp_pkg::DivSteps; i++) begin
        st_q[i].in_front <= st_q[i-1].in_front;
        st_q[i].den      <= st_q[i-1].den;
        st_q[i].u        <= div_step(st_q[i-1].u, st_q[i-1].den);
        st_q[i].v        <= div_step(st_q[i-1].v, st_q[i-1].den);
      end
      if (st_q[cpp_pkg::DivSteps].in_front) begin
        u_q    <= lane_final(st_q[cpp_pkg::DivSteps].u);
        v_q    <= lane_final(st_q[cpp_pkg::DivSteps].v);
        flag_q <= 1'b1;
      end else begin
        u_q    <= cpp_pkg::QNegOne;
        v_q    <= cpp_pkg::QNegOne;
        flag_q <= 1'b0;
      end
    end
  end

  assign empty      = !out_valid_q;
  assign pixel_u_o  = u_q;
  assign pixel_v_o  = v_q;
  assign in_front_o = flag_q;

`ifndef SYNTHESIS
  a_behind_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !in_front_o) |-> (pixel_u_o == cpp_pkg::QNegOne && pixel_v_o == cpp_pkg::QNegOne))
    else $error("point behind camera without -1 coordinates");
`endif

endmodule

FILE: rtl/camera_point_projection.sv
// Top level of the camera point projection block: registers, front, queue, back.
// Depends on cpp_pkg, cpp_front, cpp_fifo and cpp_back.
`timescale 1ns / 1ps

// Projects one signed Q16.16 point per request through the 3x4 matrix held in
// six 64-bit registers (byte address 8*i) and returns u, v in Q16.16 and the
// in-front flag. One point enters per cycle while full is low; a result passes
// four front stages (multipliers, two adder levels, depth classification), the
// request queue, and 34 back stages: the set-up stage, the 32-step restoring
// divider and the saturation register.
// Configuration writes belong to idle periods.
module camera_point_projection (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] point_z_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] pixel_u_o,
  output logic signed [31:0] pixel_v_o,
  output logic               in_front_o
);

  logic [cpp_pkg::RegW-1:0] regs_q [cpp_pkg::NumRegs];
  cpp_pkg::reg_idx_e        idx;
  logic                     wr_en;
  cpp_pkg::coef_mat_t       coef;
  logic                     job_valid, fifo_full, q_valid, q_ready;
  cpp_pkg::job_t            job, q_job;

  assign pready = 1'b1;
  assign idx    = cpp_pkg::reg_idx_e'(paddr[5:3]);
  assign wr_en  = psel && penable && pwrite;

  // Write registers; indexes past the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q[cpp_pkg::RegRow0A] <= cpp_pkg::ResetRow0A;
      regs_q[cpp_pkg::RegRow0B] <= cpp_pkg::ResetRow0B;
      regs_q[cpp_pkg::RegRow1A] <= cpp_pkg::ResetRow1A;
      regs_q[cpp_pkg::RegRow1B] <= cpp_pkg::ResetRow1B;
      regs_q[cpp_pkg::RegRow2A] <= cpp_pkg::ResetRow2A;
      regs_q[cpp_pkg::RegRow2B] <= cpp_pkg::ResetRow2B;
    end else if (wr_en) begin
      unique case (idx)
        cpp_pkg::RegRow0A: regs_q[cpp_pkg::RegRow0A] <= pwdata;
        cpp_pkg::RegRow0B: regs_q[cpp_pkg::RegRow0B] <= pwdata;
        cpp_pkg::RegRow1A: regs_q[cpp_pkg::RegRow1A] <= pwdata;
        cpp_pkg::RegRow1B: regs_q[cpp_pkg::RegRow1B] <= pwdata;
        cpp_pkg::RegRow2A: regs_q[cpp_pkg::RegRow2A] <= pwdata;
        cpp_pkg::RegRow2B: regs_q[cpp_pkg::RegRow2B] <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      cpp_pkg::RegRow0A: prdata = regs_q[cpp_pkg::RegRow0A];
      cpp_pkg::RegRow0B: prdata = regs_q[cpp_pkg::RegRow0B];
      cpp_pkg::RegRow1A: prdata = regs_q[cpp_pkg::RegRow1A];
      cpp_pkg::RegRow1B: prdata = regs_q[cpp_pkg::RegRow1B];
      cpp_pkg::RegRow2A: prdata = regs_q[cpp_pkg::RegRow2A];
      cpp_pkg::RegRow2B: prdata = regs_q[cpp_pkg::RegRow2B];
      default:           prdata = '0;
    endcase
  end

  // Unpack coefficients: even column in the upper half
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 4; c++) begin
        coef[r][c] = (c % 2 == 0) ? regs_q[r*2 + c/2][63:32] : regs_q[r*2 + c/2][31:0];
      end
    end
  end

  cpp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .coef_i      (coef),
    .push        (push),
    .full        (full),
    .point_x_i   (point_x_i),
    .point_y_i   (point_y_i),
    .point_z_i   (point_z_i),
    .job_full_i  (fifo_full),
    .job_valid_o (job_valid),
    .job_o       (job)
  );

  cpp_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (job_valid),
    .wr_data_i  (job),
    .full_o     (fifo_full),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_data_o  (q_job)
  );

  cpp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (q_job),
    .job_ready_o (q_ready),
    .empty       (empty),
    .pop         (pop),
    .pixel_u_o   (pixel_u_o),
    .pixel_v_o   (pixel_v_o),
    .in_front_o  (in_front_o)
  );

endmodule
